/* design/keyed_quantity_table_macros.svh */
`ifndef KEYED_QUANTITY_TABLE_MACROS_SVH
`define KEYED_QUANTITY_TABLE_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define KQT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed_quantity_table: same-cycle check failed");

// next-cycle implication
`define KQT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed_quantity_table: next-cycle check failed");

`endif

/* design/kqt_pkg.sv */
package kqt_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_UPDATE = 2'd2;
	localparam logic [1:0] MODE_DUMP   = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	localparam logic signed [31:0] QTY_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		OP_REPLY,
		OP_INSERT,
		OP_SEARCH,
		OP_UPDATE,
		OP_DUMP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [2:0]         status;
		logic signed [31:0] key;
		logic signed [31:0] qty;
		logic [IDX_W-1:0]   idx;
		logic [CNT_W-1:0]   n;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [31:0]      data;
	} key_wr_t;

endpackage

/* design/kqt_ram.sv */
module kqt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/kqt_front.sv */
module kqt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  logic signed [31:0]  part_key,
	input  logic signed [31:0]  quantity,
	input  logic                q_full,
	output logic                push,
	output kqt_pkg::cmd_t       push_cmd,
	output kqt_pkg::key_wr_t    key_wr
);

	logic                         s1_valid_q;
	logic [1:0]                   mode_s1;
	logic signed [31:0]           key_s1;
	logic signed [31:0]           qty_s1;
	logic [kqt_pkg::CNT_W-1:0]    count_q;
	logic [31:0]                  key_q [kqt_pkg::ENTRIES];

	logic                         accept;
	logic [kqt_pkg::ENTRIES-1:0]  match;
	logic                         hit;
	logic [kqt_pkg::IDX_W-1:0]    hit_idx;
	logic                         full;
	logic                         ins_ok;

	assign busy   = s1_valid_q & q_full;
	assign accept = start & ~busy;
	assign push   = s1_valid_q & ~q_full;
	assign full   = count_q >= kqt_pkg::CNT_W'(kqt_pkg::ENTRIES);

	// keys are unique, so at most one match bit is set and an OR encode is enough
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < kqt_pkg::ENTRIES; i++) begin
			match[i] = (key_q[i] == key_s1) && (kqt_pkg::CNT_W'(i) < count_q);
			if (match[i]) begin
				hit_idx = hit_idx | kqt_pkg::IDX_W'(i);
			end
		end
		hit = |match;
	end

	always_comb begin
		ins_ok          = 1'b0;
		push_cmd.op     = kqt_pkg::OP_REPLY;
		push_cmd.status = kqt_pkg::ST_OK;
		push_cmd.key    = key_s1;
		push_cmd.qty    = qty_s1;
		push_cmd.idx    = hit_idx;
		push_cmd.n      = count_q;
		unique case (mode_s1)
			kqt_pkg::MODE_INSERT: begin
				if (full) begin
					push_cmd.status = kqt_pkg::ST_FULL;
				end else if (hit) begin
					push_cmd.status = kqt_pkg::ST_EXISTS;
				end else begin
					ins_ok       = 1'b1;
					push_cmd.op  = kqt_pkg::OP_INSERT;
					push_cmd.idx = count_q[kqt_pkg::IDX_W-1:0];
				end
			end
			kqt_pkg::MODE_SEARCH: begin
				if (hit) begin
					push_cmd.op = kqt_pkg::OP_SEARCH;
				end else begin
					push_cmd.status = kqt_pkg::ST_NOT_FOUND;
				end
			end
			kqt_pkg::MODE_UPDATE: begin
				if (hit) begin
					push_cmd.op = kqt_pkg::OP_UPDATE;
				end else begin
					push_cmd.status = kqt_pkg::ST_NOT_FOUND;
				end
			end
			kqt_pkg::MODE_DUMP: begin
				if (count_q == '0) begin
					push_cmd.status = kqt_pkg::ST_EMPTY;
					push_cmd.key    = '0;
				end else begin
					push_cmd.op = kqt_pkg::OP_DUMP;
				end
			end
		endcase
	end

	assign key_wr.en   = push & ins_ok;
	assign key_wr.addr = count_q[kqt_pkg::IDX_W-1:0];
	assign key_wr.data = key_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			count_q    <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (push) begin
				s1_valid_q <= 1'b0;
			end
			if (key_wr.en) begin
				count_q <= count_q + kqt_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			key_s1  <= part_key;
			qty_s1  <= quantity;
		end
		if (key_wr.en) begin
			key_q[count_q[kqt_pkg::IDX_W-1:0]] <= key_s1;
		end
	end

endmodule

/* design/kqt_fifo.sv */
module kqt_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kqt_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output kqt_pkg::cmd_t head
);

	kqt_pkg::cmd_t               mem_q [kqt_pkg::Q_DEPTH];
	logic [kqt_pkg::Q_AW-1:0]    wptr_q;
	logic [kqt_pkg::Q_AW-1:0]    rptr_q;
	logic [kqt_pkg::Q_CNT_W-1:0] cnt_q;
	logic                        do_pop;

	assign full   = cnt_q == kqt_pkg::Q_CNT_W'(kqt_pkg::Q_DEPTH);
	assign empty  = cnt_q == '0;
	assign head   = mem_q[rptr_q];
	assign do_pop = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + kqt_pkg::Q_AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + kqt_pkg::Q_AW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + kqt_pkg::Q_CNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - kqt_pkg::Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

endmodule

/* design/kqt_back.sv */
module kqt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       empty,
	input  kqt_pkg::cmd_t              head,
	output logic                       pop,
	output logic [kqt_pkg::IDX_W-1:0]  rd_addr,
	input  logic [31:0]                key_rdata,
	output logic                       done,
	output logic [2:0]                 status,
	output logic signed [31:0]         found_key,
	output logic signed [31:0]         found_quantity,
	output logic                       last
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_RMW  = 2'd1;
	localparam logic [1:0] B_DUMP = 2'd2;
	localparam logic [1:0] B_TAIL = 2'd3;

	logic [1:0]                state_q;
	logic [1:0]                state_d;
	kqt_pkg::cmd_t             cur_q;
	logic [kqt_pkg::IDX_W-1:0] ptr_q;

	logic                      q_we;
	logic [kqt_pkg::IDX_W-1:0] q_waddr;
	logic [31:0]               q_wdata;
	logic [31:0]               q_rdata;

	logic signed [32:0]        sum;
	logic signed [31:0]        sat;

	logic                      o_load;
	logic [2:0]                o_status;
	logic signed [31:0]        o_key;
	logic signed [31:0]        o_qty;
	logic                      o_last;

	kqt_ram #(
		.WIDTH(32),
		.DEPTH(kqt_pkg::ENTRIES)
	) u_qty_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.raddr(rd_addr),
		.rdata(q_rdata)
	);

	assign sum = {cur_q.qty[31], cur_q.qty} + {q_rdata[31], q_rdata};
	assign sat = (sum[32] != sum[31]) ? (sum[32] ? kqt_pkg::QTY_MIN : kqt_pkg::QTY_MAX)
	                                  : sum[31:0];

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		rd_addr  = head.idx;
		q_we     = 1'b0;
		q_waddr  = head.idx;
		q_wdata  = head.qty;
		o_load   = 1'b0;
		o_status = kqt_pkg::ST_OK;
		o_key    = head.key;
		o_qty    = '0;
		o_last   = 1'b1;
		unique case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (head.op)
						kqt_pkg::OP_REPLY: begin
							o_load   = 1'b1;
							o_status = head.status;
						end
						kqt_pkg::OP_INSERT: begin
							q_we   = 1'b1;
							o_load = 1'b1;
							o_qty  = head.qty;
						end
						kqt_pkg::OP_SEARCH, kqt_pkg::OP_UPDATE: begin
							state_d = B_RMW;
						end
						kqt_pkg::OP_DUMP: begin
							rd_addr = '0;
							state_d = (head.n == kqt_pkg::CNT_W'(1)) ? B_TAIL : B_DUMP;
						end
						default: begin
						end
					endcase
				end
			end
			B_RMW: begin
				o_load = 1'b1;
				o_key  = cur_q.key;
				if (cur_q.op == kqt_pkg::OP_UPDATE) begin
					q_we    = 1'b1;
					q_waddr = cur_q.idx;
					q_wdata = sat;
					o_qty   = sat;
				end else begin
					o_qty = q_rdata;
				end
				state_d = B_IDLE;
			end
			B_DUMP: begin
				// read ahead one entry, emit the one fetched last cycle
				rd_addr = ptr_q;
				o_load  = 1'b1;
				o_key   = key_rdata;
				o_qty   = q_rdata;
				o_last  = 1'b0;
				if ({1'b0, ptr_q} == kqt_pkg::CNT_W'(cur_q.n - kqt_pkg::CNT_W'(1))) begin
					state_d = B_TAIL;
				end
			end
			B_TAIL: begin
				o_load  = 1'b1;
				o_key   = key_rdata;
				o_qty   = q_rdata;
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ptr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= o_load;
			if (pop) begin
				ptr_q <= kqt_pkg::IDX_W'(1);
			end else if (state_q == B_DUMP) begin
				ptr_q <= ptr_q + kqt_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (o_load) begin
			status         <= o_status;
			found_key      <= o_key;
			found_quantity <= o_qty;
			last           <= o_last;
		end
	end

endmodule

/* design/keyed_quantity_table.sv */
// A command is registered in the front stage, pushed into the command queue, popped
// by the back end and answered with a registered done beat. Front takes one item per
// cycle until its 4-deep command queue fills; the back end sets throughput: insert and
// reject are handled in its idle state, search and update pass through its quantity
// RAM read-modify-write state, and a dump of n entries holds it until the last entry
// is out. Reset clears the entry count, queue and control; the key and quantity stores are not cleared.
module keyed_quantity_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic signed [31:0] part_key,
	input  logic signed [31:0] quantity,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] found_key,
	output logic signed [31:0] found_quantity,
	output logic               last
);

	logic                      q_full;
	logic                      q_empty;
	logic                      push;
	logic                      pop;
	kqt_pkg::cmd_t             push_cmd;
	kqt_pkg::cmd_t             head;
	kqt_pkg::key_wr_t          key_wr;
	logic [kqt_pkg::IDX_W-1:0] rd_addr;
	logic [31:0]               key_rdata;

	kqt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.mode    (mode),
		.part_key(part_key),
		.quantity(quantity),
		.q_full  (q_full),
		.push    (push),
		.push_cmd(push_cmd),
		.key_wr  (key_wr)
	);

	kqt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.head    (head)
	);

	// copy of the keys for dump reads, written alongside the compare registers
	kqt_ram #(
		.WIDTH(32),
		.DEPTH(kqt_pkg::ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_wr.en),
		.waddr(key_wr.addr),
		.wdata(key_wr.data),
		.raddr(rd_addr),
		.rdata(key_rdata)
	);

	kqt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.head          (head),
		.pop           (pop),
		.rd_addr       (rd_addr),
		.key_rdata     (key_rdata),
		.done          (done),
		.status        (status),
		.found_key     (found_key),
		.found_quantity(found_quantity),
		.last          (last)
	);

endmodule

/* design/kqt_checker.sv */
`include "keyed_quantity_table_macros.svh"

module kqt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               done,
	input logic [2:0]         status,
	input logic signed [31:0] found_key,
	input logic signed [31:0] found_quantity,
	input logic               last
);

	// any failed operation is a single closing beat with no quantity
	`KQT_ASSERT_NOW(a_fail_single, done && status != kqt_pkg::ST_OK, last && found_quantity == '0)

	`KQT_ASSERT_NOW(a_empty_key, done && status == kqt_pkg::ST_EMPTY, found_key == '0)

	// a dump streams one beat per cycle until its last beat
	`KQT_ASSERT_NEXT(a_dump_stream, done && !last, done && status == kqt_pkg::ST_OK)

endmodule

bind keyed_quantity_table kqt_checker u_kqt_checker (.*);
